/* hw/rtl/ccsd_pkg.sv */
// ----------------------------------------------------------------------------
// Column color sequence detector package
// Shared widths, default sizes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ccsd_pkg;

    // Width of a pixel class label and of every configuration register.
    localparam int CLASS_W     = 3;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 3;
    localparam int STAGE_OUT_W = 3;

    // Default window length and sequence length.
    localparam int DEF_WINDOW_LEN = 5;
    localparam int DEF_SEQ_LEN    = 4;

    // Number of color registers; stages past the last one wrap around.
    localparam int NUM_COLORS = 4;
    localparam int COLOR_SEL_W = 2;

    typedef logic [CLASS_W-1:0] class_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SEQ_COLOR_A     = 3'd0,
        REG_SEQ_COLOR_B     = 3'd1,
        REG_SEQ_COLOR_C     = 3'd2,
        REG_SEQ_COLOR_D     = 3'd3,
        REG_MATCH_THRESHOLD = 3'd4
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam class_t SEQ_COLOR_RESET [NUM_COLORS] = '{3'd4, 3'd5, 3'd6, 3'd4};
    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 3'd3;

endpackage

/* hw/rtl/column_color_sequence_detector_unit.sv */
// ----------------------------------------------------------------------------
// Column color sequence detector
// Scans one image column of class labels and reports whether the border color
// sequence was found.
// ----------------------------------------------------------------------------
// The block takes one pixel label per clock, bottom row first, and keeps the
// last WINDOW_LEN labels plus the index of the sequence stage being searched.
// Once the window is full, a stage advances when at least match_threshold
// window labels equal that stage's color; after the last stage the rest of the
// column is ignored. A pixel marked column_start clears the column state first.
// Only a pixel marked column_last produces a result request, loaded into the
// result register from the input register. The rate is one pixel per clock
// unless a result backs up; window, fill count and stage update per pixel.
// Configuration must be written only while idle; the block does not enforce it.
module column_color_sequence_detector_unit #(
    parameter int WINDOW_LEN = ccsd_pkg::DEF_WINDOW_LEN,
    parameter int SEQ_LEN    = ccsd_pkg::DEF_SEQ_LEN
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Pixel channel.
    input  logic                               pixel_valid,
    output logic                               pixel_ready,
    input  logic [ccsd_pkg::CLASS_W-1:0]       pixel_class,
    input  logic                               column_start,
    input  logic                               column_last,
    // Result channel.
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               border_found,
    output logic [ccsd_pkg::STAGE_OUT_W-1:0]   stage_reached,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [ccsd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [ccsd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int FILL_W  = $clog2(WINDOW_LEN + 1);
    localparam int STAGE_W = $clog2(SEQ_LEN + 1);
    localparam int EXT_W   = (STAGE_W > ccsd_pkg::STAGE_OUT_W) ? STAGE_W
                                                               : ccsd_pkg::STAGE_OUT_W;
    localparam int CMP_W   = (FILL_W > ccsd_pkg::CFG_DATA_W) ? FILL_W
                                                             : ccsd_pkg::CFG_DATA_W;

    // Configuration registers.
    ccsd_pkg::class_t                 seq_color_reg [ccsd_pkg::NUM_COLORS];
    logic [ccsd_pkg::CFG_DATA_W-1:0]  match_threshold_reg;

    // Input register stage.
    logic              s1_valid_reg;
    ccsd_pkg::class_t  s1_class_reg;
    logic              s1_start_reg;
    logic              s1_last_reg;
    logic              s1_advance;
    logic              pixel_accept;

    // Column state.
    ccsd_pkg::class_t     window_reg  [WINDOW_LEN];
    ccsd_pkg::class_t     window_next [WINDOW_LEN];
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [FILL_W-1:0]    fill_cur;
    logic [STAGE_W-1:0]   stage_reg;
    logic [STAGE_W-1:0]   stage_next;
    logic [STAGE_W-1:0]   stage_cur;
    logic [EXT_W-1:0]     stage_cur_ext;
    logic [EXT_W-1:0]     stage_next_ext;
    logic [FILL_W-1:0]    hits;
    ccsd_pkg::class_t     want_color;

    // Result register.
    logic                               result_valid_reg;
    logic                               border_found_reg;
    logic [ccsd_pkg::STAGE_OUT_W-1:0]   stage_reached_reg;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ccsd_pkg::NUM_COLORS; i++)
            begin
                seq_color_reg[i] <= ccsd_pkg::SEQ_COLOR_RESET[i];
            end
            match_threshold_reg <= ccsd_pkg::THRESHOLD_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (ccsd_pkg::cfg_reg_t'(cfg_addr))
                ccsd_pkg::REG_SEQ_COLOR_A:     seq_color_reg[0]    <= cfg_wdata;
                ccsd_pkg::REG_SEQ_COLOR_B:     seq_color_reg[1]    <= cfg_wdata;
                ccsd_pkg::REG_SEQ_COLOR_C:     seq_color_reg[2]    <= cfg_wdata;
                ccsd_pkg::REG_SEQ_COLOR_D:     seq_color_reg[3]    <= cfg_wdata;
                ccsd_pkg::REG_MATCH_THRESHOLD: match_threshold_reg <= cfg_wdata;
                default:                       ;
            endcase
        end
    end

    // Handshake: a result-bearing pixel waits only while the result register
    // is full and not being taken.
    assign s1_advance   = s1_valid_reg && (!s1_last_reg || !result_valid_reg || result_ready);
    assign pixel_ready  = !s1_valid_reg || s1_advance;
    assign pixel_accept = pixel_valid && pixel_ready;

    // Input register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (pixel_ready)
        begin
            s1_valid_reg <= pixel_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (pixel_accept)
        begin
            s1_class_reg <= pixel_class;
            s1_start_reg <= column_start;
            s1_last_reg  <= column_last;
        end
    end

    // A column start clears the fill count and the stage before the pixel.
    // Old window contents are never tested until fully shifted out.
    assign fill_cur      = s1_start_reg ? '0 : fill_reg;
    assign stage_cur     = s1_start_reg ? '0 : stage_reg;
    assign stage_cur_ext = EXT_W'(stage_cur);
    assign want_color    = seq_color_reg[stage_cur_ext[ccsd_pkg::COLOR_SEL_W-1:0]];

    // Window shift, fill count and stage advance for one pixel.
    always_comb
    begin
        window_next = window_reg;
        fill_next   = fill_cur;
        stage_next  = stage_cur;
        hits        = '0;
        if (stage_cur < STAGE_W'(SEQ_LEN))
        begin
            window_next[0] = s1_class_reg;
            for (int k = 1; k < WINDOW_LEN; k++)
            begin
                window_next[k] = window_reg[k-1];
            end
            if (fill_cur != FILL_W'(WINDOW_LEN))
            begin
                fill_next = fill_cur + 1'b1;
            end
            if (fill_next == FILL_W'(WINDOW_LEN))
            begin
                for (int k = 0; k < WINDOW_LEN; k++)
                begin
                    if (window_next[k] == want_color)
                    begin
                        hits = hits + 1'b1;
                    end
                end
                if (CMP_W'(hits) >= CMP_W'(match_threshold_reg))
                begin
                    stage_next = stage_cur + 1'b1;
                end
            end
        end
    end

    assign stage_next_ext = EXT_W'(stage_next);

    // Column state control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            stage_reg <= '0;
        end
        else if (s1_advance)
        begin
            fill_reg  <= fill_next;
            stage_reg <= stage_next;
        end
    end

    // Label window; only tested once the fill count says it is full.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            window_reg <= window_next;
        end
    end

    // Result register valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            border_found_reg  <= (stage_next == STAGE_W'(SEQ_LEN));
            stage_reached_reg <= stage_next_ext[ccsd_pkg::STAGE_OUT_W-1:0];
        end
    end

    assign result_valid  = result_valid_reg;
    assign border_found  = border_found_reg;
    assign stage_reached = stage_reached_reg;

endmodule

/* hw/rtl/ccsd_checker.sv */
// ----------------------------------------------------------------------------
// Column color sequence detector checker
// Port-level assertions on the pixel and result channels.
// ----------------------------------------------------------------------------
module ccsd_checker #(
    parameter int SEQ_LEN = ccsd_pkg::DEF_SEQ_LEN
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pixel_valid,
    input  logic                               pixel_ready,
    input  logic                               column_last,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  logic                               border_found,
    input  logic [ccsd_pkg::STAGE_OUT_W-1:0]   stage_reached
);

    localparam logic [ccsd_pkg::STAGE_OUT_W-1:0] SEQ_LEN_OUT =
        ccsd_pkg::STAGE_OUT_W'(SEQ_LEN % (1 << ccsd_pkg::STAGE_OUT_W));

    // A result held back must not change.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=>
            (result_valid && $stable(border_found) && $stable(stage_reached)))
        else $error("result changed while stalled");

    // A fresh result must trace back to an accepted last pixel request.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pixel_valid && pixel_ready && column_last, 2))
        else $error("result without a last pixel request two cycles before");

    // The pixel side stalls only behind a full, untaken result register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> (result_valid && !result_ready))
        else $error("pixel channel stalled without a result backlog");

    // A found border always reports the full sequence length.
    a_border_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && border_found) |-> (stage_reached == SEQ_LEN_OUT))
        else $error("border found with a partial stage count");

endmodule

bind column_color_sequence_detector_unit ccsd_checker #(
    .SEQ_LEN (SEQ_LEN)
) u_ccsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .pixel_valid   (pixel_valid),
    .pixel_ready   (pixel_ready),
    .column_last   (column_last),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .border_found  (border_found),
    .stage_reached (stage_reached)
);

/* tb/column_color_sequence_detector_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column color sequence detector testbench
// Feeds pixel label requests with random gaps and result stalls. A local
// model of the window, fill count and stage predicts each column report. A
// checker compares every returned report, field by field, with the oldest
// prediction.
// ----------------------------------------------------------------------------
module column_color_sequence_detector_unit_tb;

    localparam int WINDOW       = ccsd_pkg::DEF_WINDOW_LEN;
    localparam int STAGES       = ccsd_pkg::DEF_SEQ_LEN;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_PIXELS = 230;

    typedef ccsd_pkg::class_t palette_t [ccsd_pkg::NUM_COLORS];

    typedef struct {
        logic                             border_found;
        logic [ccsd_pkg::STAGE_OUT_W-1:0] stage_reached;
    } column_report_t;

    logic                             clk;
    logic                             rst_n;
    logic                             pixel_valid;
    logic                             pixel_ready;
    logic [ccsd_pkg::CLASS_W-1:0]     pixel_class;
    logic                             column_start;
    logic                             column_last;
    logic                             result_valid;
    logic                             result_ready;
    logic                             border_found;
    logic [ccsd_pkg::STAGE_OUT_W-1:0] stage_reached;
    logic                             cfg_wr_en;
    logic [ccsd_pkg::CFG_ADDR_W-1:0]  cfg_addr;
    logic [ccsd_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    // Local copy of the column state and of the register settings.
    ccsd_pkg::class_t                 model_window [WINDOW];
    int                               model_fill;
    int                               model_stage;
    palette_t                         model_colors;
    logic [ccsd_pkg::CFG_DATA_W-1:0]  model_threshold;

    column_report_t         awaited_reports [$];
    int                     mismatch_count = 0;
    int                     sent_pixels = 0;
    bit                     steady_flow = 1'b0;

    column_color_sequence_detector_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel_class  (pixel_class),
        .column_start (column_start),
        .column_last  (column_last),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .border_found (border_found),
        .stage_reached(stage_reached),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    // Clear the window, the fill count and the stage of the local model.
    function automatic void clear_column_model();
        foreach (model_window[k])
        begin
            model_window[k] = '0;
        end
        model_fill  = 0;
        model_stage = 0;
    endfunction

    // Advance the local model by one accepted pixel and queue the report it asks for.
    function automatic void track_pixel(ccsd_pkg::class_t label, bit opens, bit closes);
        int             hits;
        column_report_t rep;
        if (opens)
        begin
            clear_column_model();
        end
        // Once the whole sequence has matched, the pixel leaves the window untouched.
        if (model_stage < STAGES)
        begin
            for (int k = WINDOW - 1; k > 0; k--)
            begin
                model_window[k] = model_window[k-1];
            end
            model_window[0] = label;
            if (model_fill < WINDOW)
            begin
                model_fill++;
            end
            // A partly filled window is never tested.
            if (model_fill >= WINDOW)
            begin
                hits = 0;
                foreach (model_window[k])
                begin
                    if (model_window[k] == model_colors[model_stage % ccsd_pkg::NUM_COLORS])
                    begin
                        hits++;
                    end
                end
                if (hits >= int'(model_threshold))
                begin
                    model_stage++;
                end
            end
        end
        if (closes)
        begin
            rep.border_found  = (model_stage == STAGES);
            rep.stage_reached = ccsd_pkg::STAGE_OUT_W'(model_stage);
            awaited_reports.push_back(rep);
        end
    endfunction

    // Send one pixel request; returns on the falling edge after acceptance with valid high.
    task automatic send_pixel(input ccsd_pkg::class_t label, input bit opens,
                              input bit closes);
        if (!steady_flow && $urandom_range(0, 3) == 0)
        begin
            pixel_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        pixel_valid  <= 1'b1;
        pixel_class  <= label;
        column_start <= opens;
        column_last  <= closes;
        do
        begin
            @(posedge clk);
        end
        while (!pixel_ready);
        track_pixel(label, opens, closes);
        sent_pixels++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every report has come back and the pipeline is quiet.
    task automatic wait_for_idle();
        pixel_valid <= 1'b0;
        while (awaited_reports.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    // Write all five registers while the block is idle.
    task automatic apply_settings(input palette_t colors,
                                  input logic [ccsd_pkg::CFG_DATA_W-1:0] thr);
        ccsd_pkg::cfg_reg_t              order [5];
        logic [ccsd_pkg::CFG_DATA_W-1:0] vals [5];
        order = '{ccsd_pkg::REG_SEQ_COLOR_A, ccsd_pkg::REG_SEQ_COLOR_B,
                  ccsd_pkg::REG_SEQ_COLOR_C, ccsd_pkg::REG_SEQ_COLOR_D,
                  ccsd_pkg::REG_MATCH_THRESHOLD};
        vals  = '{colors[0], colors[1], colors[2], colors[3], thr};
        foreach (order[i])
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= order[i];
            cfg_wdata <= vals[i];
            @(negedge clk);
        end
        cfg_wr_en       <= 1'b0;
        model_colors    = colors;
        model_threshold = thr;
    endtask

    // Send one column; labels lean toward the color of the stage being searched.
    task automatic send_column(input int len, input bit tidy);
        ccsd_pkg::class_t label;
        bit               opens;
        bit               closes;
        for (int n = 0; n < len; n++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                label = model_colors[model_stage % ccsd_pkg::NUM_COLORS];
            end
            else
            begin
                label = ccsd_pkg::class_t'($urandom_range(0, 7));
            end
            if (tidy)
            begin
                opens  = (n == 0);
                closes = (n == len - 1);
            end
            else
            begin
                opens  = ($urandom_range(0, 15) == 0) || (n == 0 && $urandom_range(0, 1) == 1);
                closes = ($urandom_range(0, 7) == 0) ||
                         (n == len - 1 && $urandom_range(0, 1) == 1);
            end
            send_pixel(label, opens, closes);
        end
    endtask

    // Right after reset, with no column start seen, the reset colors and threshold apply.
    task automatic test_power_on_column();
        ccsd_pkg::class_t labels [7];
        labels = '{3'd0, 3'd7, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4};
        foreach (labels[i])
        begin
            send_pixel(labels[i], 1'b0, i == 6);
        end
    endtask

    // A pixel that both opens and closes a column is a column one pixel long.
    task automatic test_one_pixel_column();
        send_pixel(3'd7, 1'b1, 1'b1);
    endtask

    // With a zero threshold every full-window test advances; the trailing pixel is ignored.
    task automatic test_threshold_zero();
        palette_t colors;
        colors = '{3'd0, 3'd7, 3'd0, 3'd7};
        wait_for_idle();
        apply_settings(colors, 3'd0);
        for (int n = 0; n < 9; n++)
        begin
            send_pixel((n % 2 == 0) ? 3'd0 : 3'd7, n == 0, n == 8);
        end
    endtask

    // A threshold above the window length never lets a stage advance.
    task automatic test_threshold_above_window();
        palette_t colors;
        colors = '{default: 3'd7};
        wait_for_idle();
        apply_settings(colors, 3'd7);
        for (int n = 0; n < 6; n++)
        begin
            send_pixel(3'd7, n == 0, n == 5);
        end
    endtask

    // Random columns over several register settings; the last phase runs without gaps.
    task automatic test_random_columns();
        palette_t                        colors;
        logic [ccsd_pkg::CFG_DATA_W-1:0] thr;
        int                              phase_first;
        int                              len;
        for (int phase = 0; phase < 8; phase++)
        begin
            foreach (colors[c])
            begin
                colors[c] = ccsd_pkg::class_t'($urandom_range(0, 7));
            end
            thr = ccsd_pkg::CFG_DATA_W'($urandom_range(1, 5));
            case (phase)
                0:
                begin
                    colors = '{default: 3'd7};
                    thr    = 3'd5;
                end
                1:
                begin
                    colors = '{default: 3'd0};
                    thr    = 3'd1;
                end
                2: thr = 3'd0;
                3: thr = 3'd7;
                4: thr = 3'd6;
                default: ;
            endcase
            wait_for_idle();
            steady_flow = (phase == 7);
            apply_settings(colors, thr);
            phase_first = sent_pixels;
            while (sent_pixels - phase_first < PHASE_PIXELS)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 120)
                                                  : $urandom_range(1, 30);
                send_column(len, $urandom_range(0, 4) != 0);
            end
        end
    endtask

    // Result side: ready toggles in random bursts, held high once the run goes steady.
    initial
    begin : result_sink
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (steady_flow || $urandom_range(0, 2) != 0)
            begin
                result_ready <= 1'b1;
            end
            else
            begin
                result_ready <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    end

    // Compare each accepted report with the oldest prediction.
    always @(posedge clk)
    begin : report_checker
        column_report_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (awaited_reports.size() == 0)
            begin
                $error("unexpected report: border_found=%0d stage_reached=%0d",
                       border_found, stage_reached);
                mismatch_count++;
            end
            else
            begin
                want = awaited_reports.pop_front();
                if (border_found !== want.border_found)
                begin
                    $error("border_found: expected %0d, actual %0d",
                           want.border_found, border_found);
                    mismatch_count++;
                end
                if (stage_reached !== want.stage_reached)
                begin
                    $error("stage_reached: expected %0d, actual %0d",
                           want.stage_reached, stage_reached);
                    mismatch_count++;
                end
            end
        end
    end

    // End the run when no request moves on either side for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((pixel_valid && pixel_ready) || (result_valid && result_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    // Main sequence: reset, directed columns, random columns, then the verdict.
    initial
    begin : run_sequence
        rst_n        = 1'b0;
        pixel_valid  = 1'b0;
        pixel_class  = '0;
        column_start = 1'b0;
        column_last  = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_addr     = ccsd_pkg::REG_SEQ_COLOR_A;
        cfg_wdata    = '0;
        model_colors    = ccsd_pkg::SEQ_COLOR_RESET;
        model_threshold = ccsd_pkg::THRESHOLD_RESET;
        clear_column_model();
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_column();
        test_one_pixel_column();
        test_threshold_zero();
        test_threshold_above_window();
        test_random_columns();

        wait_for_idle();
        repeat (8) @(negedge clk);
        if (mismatch_count == 0 && awaited_reports.size() == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ccsd_pkg.sv
hw/rtl/column_color_sequence_detector_unit.sv
hw/rtl/ccsd_checker.sv
tb/column_color_sequence_detector_unit_tb.sv
